FILE: rtl/core/bfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_pkg
// Shared types and constants of the bus frame receiver.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam logic       CMD_BYTE   = 1'b0;
    localparam logic       CMD_BREAK  = 1'b1;
    localparam logic [7:0] ADDR_RESET = 8'hF4;
    localparam logic [8:0] LEN_OFFSET = 9'd2;
    localparam logic [8:0] LEN_MIN    = 9'd3;
    localparam logic [7:0] XOR_GOOD   = 8'h00;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] byte_position;
        logic       last_of_frame;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/bfr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bfr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_front
// Takes bus events, checks address, length and checksum, writes frame bytes
// into the current store bank and posts each good frame to the replay queue.
// ----------------------------------------------------------------------------
module bfr_front #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire bfr_pkg::item_t                  item,
    input  wire logic                            cfg_we,
    input  wire logic [7:0]                      cfg_data,
    output logic                                 ram_we,
    output logic [$clog2(BUFFER_DEPTH):0]        ram_waddr,
    output logic [7:0]                           ram_wdata,
    output logic                                 q_push,
    output logic                                 q_bank,
    output logic [$clog2(BUFFER_DEPTH+1)-1:0]    q_len
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [7:0]    addr_reg;
    logic          armed_reg, armed_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [7:0]    xor_reg, xor_next;
    logic [CW-1:0] exp_reg, exp_next;
    logic          bank_reg, bank_next;

    logic [CW-1:0] fill_inc;
    logic [7:0]    xor_new;
    logic [8:0]    len_sum;
    logic          len_ok;
    logic          store;

    assign fill_inc  = fill_reg + CW'(1);
    assign xor_new   = xor_reg ^ item.rx_byte;
    assign len_sum   = {1'b0, item.rx_byte} + bfr_pkg::LEN_OFFSET;
    assign len_ok    = (len_sum >= bfr_pkg::LEN_MIN) && (len_sum <= 9'(BUFFER_DEPTH));
    assign store     = accept && (item.cmd == bfr_pkg::CMD_BYTE) && armed_reg
                       && !((fill_reg == '0) && (item.rx_byte != addr_reg))
                       && (fill_reg < CW'(BUFFER_DEPTH));

    assign ram_we    = store;
    assign ram_waddr = {bank_reg, fill_reg[AW-1:0]};
    assign ram_wdata = item.rx_byte;
    assign q_bank    = bank_reg;
    assign q_len     = fill_inc;

    always_comb
    begin
        armed_next = armed_reg;
        fill_next  = fill_reg;
        xor_next   = xor_reg;
        exp_next   = exp_reg;
        bank_next  = bank_reg;
        q_push     = 1'b0;
        if (accept)
        begin
            if (item.cmd == bfr_pkg::CMD_BREAK)
            begin
                armed_next = 1'b1;
                fill_next  = '0;
                xor_next   = '0;
            end
            else if (armed_reg)
            begin
                if (!store)
                begin
                    // wrong address or overrun: drop until the next break
                    armed_next = 1'b0;
                    fill_next  = '0;
                    xor_next   = '0;
                    exp_next   = '0;
                end
                else if (fill_inc == CW'(2))
                begin
                    if (len_ok)
                    begin
                        fill_next = fill_inc;
                        xor_next  = xor_new;
                        exp_next  = len_sum[CW-1:0];
                    end
                    else
                    begin
                        armed_next = 1'b0;
                        fill_next  = '0;
                        xor_next   = '0;
                        exp_next   = '0;
                    end
                end
                else if ((fill_inc >= CW'(3)) && (fill_inc == exp_reg))
                begin
                    fill_next = '0;
                    xor_next  = '0;
                    if (xor_new == bfr_pkg::XOR_GOOD)
                    begin
                        // hand the bank to the replay side, fill the other one
                        q_push    = 1'b1;
                        bank_next = ~bank_reg;
                    end
                    else
                    begin
                        armed_next = 1'b0;
                        exp_next   = '0;
                    end
                end
                else
                begin
                    fill_next = fill_inc;
                    xor_next  = xor_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= bfr_pkg::ADDR_RESET;
            armed_reg <= 1'b0;
            fill_reg  <= '0;
            xor_reg   <= '0;
            exp_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                addr_reg <= cfg_data;
            end
            armed_reg <= armed_next;
            fill_reg  <= fill_next;
            xor_reg   <= xor_next;
            exp_reg   <= exp_next;
            bank_reg  <= bank_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_queue
// Two-entry queue of completed frames (store bank and length) between the
// front and the replay side. An entry holds its bank until replay is done.
// ----------------------------------------------------------------------------
module bfr_queue #(
    parameter int LEN_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_push,
    input  wire logic             q_bank,
    input  wire logic [LEN_W-1:0] q_len,
    input  wire logic             q_pop,
    output logic                  head_valid,
    output logic                  head_bank,
    output logic [LEN_W-1:0]      head_len,
    output logic                  q_full
);

    logic             bank_reg [2];
    logic [LEN_W-1:0] len_reg  [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign head_valid = (count_reg != 2'd0);
    assign q_full     = (count_reg == 2'd2);
    assign head_bank  = bank_reg[rd_ptr_reg];
    assign head_len   = len_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ q_push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + {1'b0, q_push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            bank_reg[wr_ptr_reg] <= q_bank;
            len_reg[wr_ptr_reg]  <= q_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bfr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfr_back
// Replays a completed frame from its store bank into the result register,
// address byte first, last byte marked.
// ----------------------------------------------------------------------------
module bfr_back #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               head_valid,
    input  wire logic                               head_bank,
    input  wire logic [$clog2(BUFFER_DEPTH+1)-1:0]  head_len,
    output logic                                    q_pop,
    output logic                                    rd_en,
    output logic [$clog2(BUFFER_DEPTH):0]           rd_addr,
    input  wire logic [7:0]                         rd_data,
    input  wire logic                               pop,
    output logic                                    empty,
    output bfr_pkg::result_t                        result
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = (CW > 6) ? CW : 6;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic             pend_reg;
    logic [CW-1:0]    pend_pos_reg;
    logic             pend_last_reg;
    logic             out_valid_reg;
    bfr_pkg::result_t out_reg;

    logic             pop_acc;
    logic             is_last;
    logic [PW-1:0]    pos_wide;

    assign pop_acc  = pop && out_valid_reg;
    assign is_last  = ((pos_reg + CW'(1)) == head_len);
    assign rd_addr  = {head_bank, pos_reg[AW-1:0]};
    assign pos_wide = PW'(pend_pos_reg);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        rd_en      = 1'b0;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    pos_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // one read in flight; issue only when the result slot frees up
                if (!pend_reg && (!out_valid_reg || pop_acc))
                begin
                    rd_en    = 1'b1;
                    pos_next = pos_reg + CW'(1);
                    if (is_last)
                    begin
                        q_pop      = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pend_pos_reg  <= pos_reg;
            pend_last_reg <= is_last;
        end
        if (pend_reg)
        begin
            out_reg.frame_byte    <= rd_data;
            out_reg.byte_position <= pos_wide[5:0];
            out_reg.last_of_frame <= pend_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            pend_reg  <= rd_en;
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop_acc)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/bus_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bus_frame_receiver
// Serial bus deframer with address match, length check and XOR checksum.
// ----------------------------------------------------------------------------
// Each event (byte or line break) is taken by the front while full is low;
// the front writes frame bytes into one of two store banks. A good frame is
// posted to a two-entry queue and replayed by the back: with pop held high,
// results are paced by the registered store read with one read in flight:
// a read waits for the last byte to reach the result slot. The front keeps
// taking events for the next frame in the other bank during replay; full is
// high while two good frames are held, i.e. until the older one's last byte is
// read from the store. The store is not cleared: only bytes of the frame
// being replayed are ever read.
module bus_frame_receiver #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire bfr_pkg::item_t    item,
    output logic                   empty,
    input  wire logic              pop,
    output bfr_pkg::result_t       result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic          accept;
    logic          cfg_we;
    logic          ram_we;
    logic [AW:0]   ram_waddr;
    logic [7:0]    ram_wdata;
    logic          rd_en;
    logic [AW:0]   rd_addr;
    logic [7:0]    rd_data;
    logic          q_push;
    logic          q_bank;
    logic [CW-1:0] q_len;
    logic          q_pop;
    logic          q_full;
    logic          head_valid;
    logic          head_bank;
    logic [CW-1:0] head_len;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign full      = q_full;
    assign accept    = push && !full;

    bfr_front #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .ram_we   (ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .q_push   (q_push),
        .q_bank   (q_bank),
        .q_len    (q_len)
    );

    bfr_ram #(
        .WIDTH(8),
        .DEPTH(2 << AW)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    bfr_queue #(
        .LEN_W(CW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_push    (q_push),
        .q_bank    (q_bank),
        .q_len     (q_len),
        .q_pop     (q_pop),
        .head_valid(head_valid),
        .head_bank (head_bank),
        .head_len  (head_len),
        .q_full    (q_full)
    );

    bfr_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head_bank (head_bank),
        .head_len  (head_len),
        .q_pop     (q_pop),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

    // front must never write the bank that is being replayed
    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && rd_en) |-> (ram_waddr[AW] != rd_addr[AW]))
        else $error("store write hit the bank under replay");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("frame posted to a full queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> head_valid)
        else $error("frame released from an empty queue");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives byte and line-break events into the bus frame receiver and checks
// every replayed frame byte against a cycle-free deframer model or typed rows. A
// short table of hand-picked events comes first. Several phases of random
// frames with different match addresses follow: mostly well-formed frames,
// plus bad checksums, wrong addresses, bad lengths, cut-off frames and noise.
// Both sides idle at random, and one phase holds the result side off long
// enough to fill the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH     = 64;
    localparam int MAX_GAP   = 18;
    localparam int HOLD_LEN  = 300;
    localparam int SETTLE    = 40;
    localparam int PHASE_LEN = 40;

    typedef struct {
        bfr_pkg::item_t         ev;
        int                     n_typed;   // -1: take the model's prediction
        bfr_pkg::result_t [2:0] typed;
    } stim_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    bfr_pkg::item_t   item = '0;
    logic             empty;
    logic             pop = 1'b0;
    bfr_pkg::result_t result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [7:0]       cfg_data = '0;

    // deframer model state
    logic [7:0] match_addr;
    logic       armed;
    logic [6:0] fill;
    logic [7:0] xsum;
    logic [8:0] frame_len;
    logic [7:0] frame_mem [DEPTH];

    bfr_pkg::result_t replay_q [$];
    bfr_pkg::result_t frame_bytes_due [$];
    stim_t            event_q [$];

    int  mismatch_count = 0;
    int  max_gap = MAX_GAP;
    bit  hold_req = 1'b0;
    bit  hold_off = 1'b0;

    bus_frame_receiver #(
        .BUFFER_DEPTH (DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("bus_frame_receiver test failed");
        $finish;
    end

    function automatic void drop_frame();
        armed     = 1'b0;
        fill      = '0;
        xsum      = '0;
        frame_len = '0;
    endfunction

    // Advance the model by one event; replayed bytes land in replay_q.
    function automatic void deframe_step(input bfr_pkg::item_t ev);
        int k;
        if (ev.cmd == bfr_pkg::CMD_BREAK)
        begin
            armed = 1'b1;
            fill  = '0;
            xsum  = '0;
            return;
        end
        if (!armed)
            return;
        if (fill == 0 && ev.rx_byte != match_addr)
        begin
            drop_frame();
            return;
        end
        if (fill >= DEPTH)
        begin
            drop_frame();
            return;
        end
        frame_mem[fill[5:0]] = ev.rx_byte;
        xsum = xsum ^ ev.rx_byte;
        fill = fill + 7'd1;
        if (fill == 7'd2)
        begin
            frame_len = {1'b0, ev.rx_byte} + bfr_pkg::LEN_OFFSET;
            if (frame_len < bfr_pkg::LEN_MIN || frame_len > DEPTH)
                drop_frame();
            return;
        end
        if (fill < 7'd3 || {2'b00, fill} != frame_len)
            return;
        if (xsum != bfr_pkg::XOR_GOOD)
        begin
            drop_frame();
            return;
        end
        for (k = 0; k < int'(fill); k++)
            replay_q.push_back('{frame_byte: frame_mem[k], byte_position: k[5:0],
                                 last_of_frame: (k + 1 == int'(fill))});
        fill = '0;
        xsum = '0;
    endfunction

    function automatic void note_fail(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%t: %s", $realtime, msg);
    endfunction

    function automatic void check_frame_byte(input bfr_pkg::result_t got);
        bfr_pkg::result_t want;
        if (frame_bytes_due.size() == 0)
        begin
            note_fail($sformatf("unexpected frame byte %h pos %0d last %b",
                                got.frame_byte, got.byte_position, got.last_of_frame));
            return;
        end
        want = frame_bytes_due.pop_front();
        if (got.frame_byte != want.frame_byte)
            note_fail($sformatf("frame_byte: expected %h, got %h",
                                want.frame_byte, got.frame_byte));
        if (got.byte_position != want.byte_position)
            note_fail($sformatf("byte_position: expected %0d, got %0d",
                                want.byte_position, got.byte_position));
        if (got.last_of_frame != want.last_of_frame)
            note_fail($sformatf("last_of_frame: expected %b, got %b",
                                want.last_of_frame, got.last_of_frame));
    endfunction

    function automatic bfr_pkg::result_t rb(input logic [7:0] b, input logic [5:0] p,
                                            input logic l);
        return '{frame_byte: b, byte_position: p, last_of_frame: l};
    endfunction

    function automatic void add_row(input logic c, input logic [7:0] b, input int n,
                                    input bfr_pkg::result_t r0,
                                    input bfr_pkg::result_t r1,
                                    input bfr_pkg::result_t r2);
        stim_t s;
        s.ev       = '{cmd: c, rx_byte: b};
        s.n_typed  = n;
        s.typed[0] = r0;
        s.typed[1] = r1;
        s.typed[2] = r2;
        event_q.push_back(s);
    endfunction

    function automatic void add_event(input logic c, input logic [7:0] b);
        add_row(c, b, -1, '0, '0, '0);
    endfunction

    // Directed table: match address at its reset value throughout.
    function automatic void load_directed();
        add_row(bfr_pkg::CMD_BYTE,  8'h5A, 0, '0, '0, '0);    // disarmed, ignored
        add_event(bfr_pkg::CMD_BREAK, 8'hFF);
        add_event(bfr_pkg::CMD_BYTE,  8'hF4);
        add_event(bfr_pkg::CMD_BYTE,  8'h01);
        add_row(bfr_pkg::CMD_BYTE,  8'hF5, 3, rb(8'hF4, 6'd0, 1'b0),
                rb(8'h01, 6'd1, 1'b0), rb(8'hF5, 6'd2, 1'b1)); // shortest good frame
        add_row(bfr_pkg::CMD_BYTE,  8'h00, 0, '0, '0, '0);    // wrong address
        add_row(bfr_pkg::CMD_BYTE,  8'hF4, 0, '0, '0, '0);    // disarmed again
        add_event(bfr_pkg::CMD_BREAK, 8'h00);
        add_event(bfr_pkg::CMD_BYTE,  8'hF4);
        add_row(bfr_pkg::CMD_BYTE,  8'h00, 0, '0, '0, '0);    // length too short
        add_event(bfr_pkg::CMD_BREAK, 8'h00);
        add_event(bfr_pkg::CMD_BYTE,  8'hF4);
        add_row(bfr_pkg::CMD_BYTE,  8'h3F, 0, '0, '0, '0);    // length past the store
        add_event(bfr_pkg::CMD_BREAK, 8'h00);
        add_event(bfr_pkg::CMD_BYTE,  8'hF4);
        add_event(bfr_pkg::CMD_BYTE,  8'h02);
        add_event(bfr_pkg::CMD_BYTE,  8'h12);
        add_row(bfr_pkg::CMD_BYTE,  8'h00, 0, '0, '0, '0);    // bad checksum
        add_event(bfr_pkg::CMD_BREAK, 8'h00);
        add_event(bfr_pkg::CMD_BYTE,  8'hF4);
        add_event(bfr_pkg::CMD_BYTE,  8'h02);
        add_event(bfr_pkg::CMD_BREAK, 8'h00);                 // break mid-frame
        add_event(bfr_pkg::CMD_BYTE,  8'hF4);
        add_event(bfr_pkg::CMD_BYTE,  8'h02);
        add_event(bfr_pkg::CMD_BYTE,  8'hFF);
        add_event(bfr_pkg::CMD_BYTE,  8'h09);
    endfunction

    // Random phase: mostly well-formed frames, the rest broken ones and noise.
    function automatic void load_random(input int n_items, input bit force_max);
        int         kind;
        int         len;
        int         i;
        bit         gen_armed;
        bit         want_max;
        logic [7:0] b;
        logic [7:0] cks;
        gen_armed = 1'b0;
        want_max  = force_max;
        while (event_q.size() < n_items)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                if (!gen_armed || $urandom_range(0, 3) == 0)
                    add_event(bfr_pkg::CMD_BREAK, 8'($urandom_range(0, 255)));
                if (want_max || $urandom_range(0, 29) == 0)
                    len = DEPTH - 2;
                else
                    len = $urandom_range(1, 10);
                want_max = 1'b0;
                cks = match_addr ^ 8'(len);
                add_event(bfr_pkg::CMD_BYTE, match_addr);
                add_event(bfr_pkg::CMD_BYTE, 8'(len));
                for (i = 0; i < len - 1; i++)
                begin
                    b = 8'($urandom_range(0, 255));
                    cks = cks ^ b;
                    add_event(bfr_pkg::CMD_BYTE, b);
                end
                gen_armed = 1'b1;
                if ($urandom_range(0, 7) == 0)
                begin
                    cks = cks ^ 8'($urandom_range(1, 255));
                    gen_armed = 1'b0;
                end
                add_event(bfr_pkg::CMD_BYTE, cks);
            end
            else if (kind < 80)
            begin
                add_event(bfr_pkg::CMD_BREAK, 8'($urandom_range(0, 255)));
                do
                    b = 8'($urandom_range(0, 255));
                while (b == match_addr);
                add_event(bfr_pkg::CMD_BYTE, b);
                add_event(bfr_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
                add_event(bfr_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
                gen_armed = 1'b0;
            end
            else if (kind < 88)
            begin
                add_event(bfr_pkg::CMD_BREAK, 8'($urandom_range(0, 255)));
                add_event(bfr_pkg::CMD_BYTE, match_addr);
                if ($urandom_range(0, 2) == 0)
                    add_event(bfr_pkg::CMD_BYTE, 8'h00);
                else
                    add_event(bfr_pkg::CMD_BYTE, 8'($urandom_range(DEPTH - 1, 255)));
                add_event(bfr_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
                add_event(bfr_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
                gen_armed = 1'b0;
            end
            else if (kind < 94)
            begin
                // cut off before its last byte; what follows is a break or noise
                add_event(bfr_pkg::CMD_BREAK, 8'($urandom_range(0, 255)));
                len = $urandom_range(3, 10);
                add_event(bfr_pkg::CMD_BYTE, match_addr);
                add_event(bfr_pkg::CMD_BYTE, 8'(len));
                for (i = $urandom_range(1, len - 1); i > 0; i--)
                    add_event(bfr_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
                gen_armed = 1'b0;
            end
            else
            begin
                for (i = $urandom_range(1, 4); i > 0; i--)
                    add_event(($urandom_range(0, 3) == 0) ? bfr_pkg::CMD_BREAK
                                                          : bfr_pkg::CMD_BYTE,
                              8'($urandom_range(0, 255)));
                gen_armed = 1'b0;
            end
        end
    endfunction

    task automatic send_events();
        stim_t s;
        int    gap;
        int    i;
        while (event_q.size() > 0)
        begin
            s = event_q.pop_front();
            gap = hold_off ? 0 : $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            push <= 1'b1;
            item <= s.ev;
            @(posedge clk);
            while (full)
                @(posedge clk);
            deframe_step(s.ev);
            if (s.n_typed >= 0)
            begin
                replay_q.delete();
                for (i = 0; i < s.n_typed; i++)
                    frame_bytes_due.push_back(s.typed[i]);
            end
            else
            begin
                while (replay_q.size() > 0)
                    frame_bytes_due.push_back(replay_q.pop_front());
            end
        end
        push <= 1'b0;
    endtask

    task automatic settle();
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_match_addr(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        match_addr = value;
    endtask

    // Result side: random pauses between requests, long hold on demand.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            while (hold_off)
            begin
                pop <= 1'b0;
                @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            check_frame_byte(result);
        end
    end

    initial
    begin
        wait (hold_req);
        hold_off = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        logic [7:0] phase_addr [4];
        int         p;
        phase_addr[0] = 8'h00;
        phase_addr[1] = 8'hFF;
        phase_addr[2] = 8'($urandom_range(0, 255));
        phase_addr[3] = bfr_pkg::ADDR_RESET;
        match_addr = bfr_pkg::ADDR_RESET;
        drop_frame();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_directed();
        send_events();
        settle();

        for (p = 0; p < 4; p++)
        begin
            write_match_addr(phase_addr[p]);
            max_gap = (p == 1) ? 0 : MAX_GAP;
            load_random(PHASE_LEN, p == 2);
            if (p == 0)
                hold_req = 1'b1;
            send_events();
            settle();
        end

        if (mismatch_count == 0)
            $display("bus_frame_receiver test passed");
        else
            $display("bus_frame_receiver test failed");
        $finish;
    end

endmodule
